// File: hw/rtl/dru_pkg.sv
// ----------------------------------------------------------------------------
// dru_pkg
// Shared types and constants of the detection row decoder.
// ----------------------------------------------------------------------------
package dru_pkg;

  localparam int MAX_ROW_LENGTH_DEF = 1024;
  localparam int MAX_FRAME_DIM_DEF  = 4096;

  localparam int ATTR_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 17;
  localparam int DIM_W    = 13;
  localparam int ROWCFG_W = 11;
  localparam int CLS_W    = 10;
  localparam int CONF_W   = 17;
  localparam int LEFT_W   = 12;

  // divisor holds model size times two to the 17th (left, top) or 16th
  localparam int DIVR_W   = DIM_W + 17;

  localparam logic signed [ATTR_W-1:0] Q_ONE      = 32'sd65536;
  localparam logic signed [ATTR_W-1:0] NORM_LIMIT = 32'sd98304;
  localparam int DEFAULT_ROW_MARK = 85;
  localparam int IMPLICIT_MIN_LEN = 8;
  localparam int MIN_ROW_LENGTH   = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_MODEL_WIDTH  = 3'd2,
    REG_MODEL_HEIGHT = 3'd3,
    REG_ROW_LENGTH   = 3'd4,
    REG_CLASS_COUNT  = 3'd5,
    REG_THRESHOLD    = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    SEL_LEFT   = 2'd0,
    SEL_TOP    = 2'd1,
    SEL_WIDTH  = 2'd2,
    SEL_HEIGHT = 2'd3
  } box_sel_t;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_MUL,
    ST_DECIDE,
    ST_PREP,
    ST_START,
    ST_WAIT,
    ST_STORE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic     accept;
    logic     mul_en;
    logic     prep;
    logic     div_start;
    logic     store;
    logic     load;
    box_sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic row_end;
    logic emit;
    logic div_busy;
  } status_t;

endpackage

// File: hw/rtl/dru_if.sv
// ----------------------------------------------------------------------------
// dru_if
// Channel interfaces: attribute input, box output and register writes.
// ----------------------------------------------------------------------------
interface dru_attr_if;
  logic                           valid;
  logic                           ready;
  logic signed [dru_pkg::ATTR_W-1:0] attribute_value;
  modport source (output valid, output attribute_value, input ready);
  modport sink (input valid, input attribute_value, output ready);
endinterface

interface dru_box_if;
  logic                          valid;
  logic                          ready;
  logic [dru_pkg::LEFT_W-1:0]    box_left;
  logic [dru_pkg::LEFT_W-1:0]    box_top;
  logic [dru_pkg::DIM_W-1:0]     box_width;
  logic [dru_pkg::DIM_W-1:0]     box_height;
  logic [dru_pkg::CLS_W-1:0]     class_index;
  logic [dru_pkg::CONF_W-1:0]    confidence;
  modport source (output valid, output box_left, output box_top, output box_width,
                  output box_height, output class_index, output confidence, input ready);
  modport sink (input valid, input box_left, input box_top, input box_width,
                input box_height, input class_index, input confidence, output ready);
endinterface

interface dru_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dru_pkg::CFG_IDX_W-1:0]   index;
  logic [dru_pkg::CFG_DAT_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/dru_ctrl.sv
// ----------------------------------------------------------------------------
// dru_ctrl
// Row sequencer: accumulate, confidence check, four box divisions, output.
// ----------------------------------------------------------------------------
module dru_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dru_pkg::status_t  status,
  output dru_pkg::cmd_t     cmd
);

  dru_pkg::state_t   state, state_next;
  dru_pkg::box_sel_t sel, sel_next;
  logic              out_full, out_full_next;
  logic              out_free;

  assign out_free = !out_full || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= dru_pkg::ST_ACCUM;
      sel      <= dru_pkg::SEL_LEFT;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      sel      <= sel_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    state_next    = state;
    sel_next      = sel;
    out_full_next = out_full;
    if (out_ready) out_full_next = 1'b0;
    case (state)
      dru_pkg::ST_ACCUM: begin
        if (in_valid && status.row_end) state_next = dru_pkg::ST_MUL;
      end
      dru_pkg::ST_MUL: state_next = dru_pkg::ST_DECIDE;
      dru_pkg::ST_DECIDE: begin
        sel_next   = dru_pkg::SEL_LEFT;
        state_next = status.emit ? dru_pkg::ST_PREP : dru_pkg::ST_ACCUM;
      end
      dru_pkg::ST_PREP:  state_next = dru_pkg::ST_START;
      dru_pkg::ST_START: state_next = dru_pkg::ST_WAIT;
      dru_pkg::ST_WAIT: begin
        if (!status.div_busy) state_next = dru_pkg::ST_STORE;
      end
      dru_pkg::ST_STORE: begin
        if (sel == dru_pkg::SEL_HEIGHT) begin
          state_next = dru_pkg::ST_OUT;
        end else begin
          sel_next   = dru_pkg::box_sel_t'(sel + 2'd1);
          state_next = dru_pkg::ST_PREP;
        end
      end
      dru_pkg::ST_OUT: begin
        if (out_free) begin
          state_next    = dru_pkg::ST_ACCUM;
          out_full_next = 1'b1;
        end
      end
      default: state_next = dru_pkg::ST_ACCUM;
    endcase
  end

  always_comb begin
    in_ready      = (state == dru_pkg::ST_ACCUM);
    out_valid     = out_full;
    cmd.accept    = in_valid && (state == dru_pkg::ST_ACCUM);
    cmd.mul_en    = (state == dru_pkg::ST_MUL);
    cmd.prep      = (state == dru_pkg::ST_PREP);
    cmd.div_start = (state == dru_pkg::ST_START);
    cmd.store     = (state == dru_pkg::ST_STORE);
    cmd.load      = (state == dru_pkg::ST_OUT) && out_free;
    cmd.sel       = sel;
  end

endmodule

// File: hw/rtl/dru_div.sv
// ----------------------------------------------------------------------------
// dru_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dru_div #(
  parameter int DW  = 48,
  parameter int DVW = 30
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic           busy,
  output logic [DW-1:0]  quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DVW-1:0]   rem;
  logic [CNT_W-1:0] cnt;
  logic [DVW:0]     trial;
  logic             fits;

  assign trial = {rem, quotient[DW-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? DVW'(trial - {1'b0, divisor}) : DVW'(trial);
      quotient <= {quotient[DW-2:0], fits};
    end
  end

endmodule

// File: hw/rtl/dru_dp.sv
// ----------------------------------------------------------------------------
// dru_dp
// Datapath: registers, row accumulation, confidence product, box scaling.
// ----------------------------------------------------------------------------
module dru_dp #(
  parameter int MAX_ROW_LENGTH = dru_pkg::MAX_ROW_LENGTH_DEF,
  parameter int MAX_FRAME_DIM  = dru_pkg::MAX_FRAME_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  dru_pkg::cmd_t                      cmd,
  output dru_pkg::status_t                   status,
  input  logic signed [dru_pkg::ATTR_W-1:0]  attribute_value,
  input  logic                               cfg_valid,
  input  logic [dru_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dru_pkg::CFG_DAT_W-1:0]      cfg_data,
  output logic [dru_pkg::LEFT_W-1:0]         box_left,
  output logic [dru_pkg::LEFT_W-1:0]         box_top,
  output logic [dru_pkg::DIM_W-1:0]          box_width,
  output logic [dru_pkg::DIM_W-1:0]          box_height,
  output logic [dru_pkg::CLS_W-1:0]          class_index,
  output logic [dru_pkg::CONF_W-1:0]         confidence
);

  localparam int LEN_W = $clog2(MAX_ROW_LENGTH + 1);
  localparam int CNT_W = $clog2(MAX_ROW_LENGTH);
  localparam int FW_W  = $clog2(MAX_FRAME_DIM + 1);
  localparam int DW    = 33 + FW_W;
  localparam int DVW   = dru_pkg::DIVR_W;
  localparam int AW    = dru_pkg::ATTR_W;

  // registers
  logic [dru_pkg::DIM_W-1:0]    frame_width, frame_height, model_width, model_height;
  logic [dru_pkg::ROWCFG_W-1:0] row_length;
  logic [dru_pkg::CLS_W-1:0]    class_name_count;
  logic [dru_pkg::CONF_W-1:0]   score_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= 13'd640;
      frame_height     <= 13'd480;
      model_width      <= 13'd640;
      model_height     <= 13'd640;
      row_length       <= 11'd85;
      class_name_count <= '0;
      score_threshold  <= 17'd16384;
    end else if (cfg_valid) begin
      case (cfg_index)
        dru_pkg::REG_FRAME_WIDTH:  frame_width      <= cfg_data[dru_pkg::DIM_W-1:0];
        dru_pkg::REG_FRAME_HEIGHT: frame_height     <= cfg_data[dru_pkg::DIM_W-1:0];
        dru_pkg::REG_MODEL_WIDTH:  model_width      <= cfg_data[dru_pkg::DIM_W-1:0];
        dru_pkg::REG_MODEL_HEIGHT: model_height     <= cfg_data[dru_pkg::DIM_W-1:0];
        dru_pkg::REG_ROW_LENGTH:   row_length       <= cfg_data[dru_pkg::ROWCFG_W-1:0];
        dru_pkg::REG_CLASS_COUNT:  class_name_count <= cfg_data[dru_pkg::CLS_W-1:0];
        dru_pkg::REG_THRESHOLD:    score_threshold  <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [LEN_W-1:0]          len_eff;
  logic [FW_W-1:0]           fw_eff, fh_eff;
  logic [dru_pkg::DIM_W-1:0] mw_eff, mh_eff;
  logic                      start4;

  always_comb begin
    if (32'(row_length) < dru_pkg::MIN_ROW_LENGTH) len_eff = LEN_W'(dru_pkg::MIN_ROW_LENGTH);
    else if (32'(row_length) > MAX_ROW_LENGTH) len_eff = LEN_W'(MAX_ROW_LENGTH);
    else len_eff = LEN_W'(row_length);

    if (frame_width == '0) fw_eff = FW_W'(1);
    else if (32'(frame_width) > MAX_FRAME_DIM) fw_eff = FW_W'(MAX_FRAME_DIM);
    else fw_eff = FW_W'(frame_width);

    if (frame_height == '0) fh_eff = FW_W'(1);
    else if (32'(frame_height) > MAX_FRAME_DIM) fh_eff = FW_W'(MAX_FRAME_DIM);
    else fh_eff = FW_W'(frame_height);

    mw_eff = (model_width == '0) ? 13'd1 : model_width;
    mh_eff = (model_height == '0) ? 13'd1 : model_height;

    if (class_name_count != '0)
      start4 = (32'(len_eff) == 32'(class_name_count) + 32'd4);
    else
      start4 = (32'(len_eff) >= dru_pkg::IMPLICIT_MIN_LEN) &&
               (32'(len_eff) != dru_pkg::DEFAULT_ROW_MARK);
  end

  // row accumulation
  logic [CNT_W-1:0]             attribute_counter;
  logic signed [AW-1:0]         raw_box [4];
  logic signed [AW-1:0]         objectness_value;
  logic signed [AW-1:0]         best_score;
  logic [dru_pkg::CLS_W-1:0]    best_class;
  logic                         class_found;

  logic                         stale, is_score, upd, last;
  logic [CNT_W-1:0]             c;
  logic signed [AW-1:0]         best_cur, best_nx;
  logic [dru_pkg::CLS_W-1:0]    cls_cur, cls_nx;
  logic                         found_cur, found_nx;

  always_comb begin
    stale     = (LEN_W'(attribute_counter) >= len_eff);
    c         = stale ? '0 : attribute_counter;
    best_cur  = stale ? '0 : best_score;
    cls_cur   = stale ? '0 : best_class;
    found_cur = stale ? 1'b0 : class_found;
    is_score  = (32'(c) >= (start4 ? 32'd4 : 32'd5));
    upd       = is_score && (attribute_value > best_cur);
    best_nx   = upd ? attribute_value : best_cur;
    cls_nx    = upd ? dru_pkg::CLS_W'(32'(c) - (start4 ? 32'd4 : 32'd5)) : cls_cur;
    found_nx  = upd || found_cur;
    last      = (32'(c) + 32'd1 == 32'(len_eff));
  end

  assign status.row_end = last;

  logic signed [AW-1:0]      snap_obj, snap_best;
  logic [dru_pkg::CLS_W-1:0] snap_cls;
  logic                      snap_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute_counter <= '0;
      raw_box[0]        <= '0;
      raw_box[1]        <= '0;
      raw_box[2]        <= '0;
      raw_box[3]        <= '0;
      objectness_value  <= '0;
      best_score        <= '0;
      best_class        <= '0;
      class_found       <= 1'b0;
      snap_found        <= 1'b0;
    end else if (cmd.accept) begin
      if (32'(c) < 32'd4) raw_box[c[1:0]] <= attribute_value;
      if (32'(c) == 32'd4) objectness_value <= attribute_value;
      if (last) begin
        attribute_counter <= '0;
        best_score        <= '0;
        best_class        <= '0;
        class_found       <= 1'b0;
        snap_found        <= found_nx;
      end else begin
        attribute_counter <= c + 1'b1;
        best_score        <= best_nx;
        best_class        <= cls_nx;
        class_found       <= found_nx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && last) begin
      snap_best <= best_nx;
      snap_cls  <= cls_nx;
      snap_obj  <= start4 ? dru_pkg::Q_ONE : objectness_value;
    end
  end

  // confidence
  logic signed [2*AW-1:0]     prod;
  logic signed [47:0]         conf;
  logic                       emit;
  logic [dru_pkg::CONF_W-1:0] conf_sat;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= snap_obj * snap_best;
  end

  always_comb begin
    conf = prod[63:16];
    emit = snap_found && (conf >= $signed({31'b0, score_threshold}));
    if (conf < 0) conf_sat = '0;
    else if (conf > 48'sd65536) conf_sat = 17'd65536;
    else conf_sat = conf[16:0];
  end

  assign status.emit = emit;

  // box scaling
  logic                   norm;
  logic signed [33:0]     a;
  logic [32:0]            mag;
  logic [FW_W-1:0]        f;
  logic [dru_pkg::DIM_W-1:0] m;
  logic [DW-1:0]          pm;
  logic [DW-1:0]          dividend;
  logic [DVW-1:0]         divisor;
  logic                   neg;
  logic                   div_busy;
  logic [DW-1:0]          q;

  always_comb begin
    norm = !raw_box[0][AW-1] && !raw_box[1][AW-1] &&
           (raw_box[2] > 0) && (raw_box[3] > 0) &&
           (raw_box[0] <= dru_pkg::NORM_LIMIT) && (raw_box[1] <= dru_pkg::NORM_LIMIT) &&
           (raw_box[2] <= dru_pkg::NORM_LIMIT) && (raw_box[3] <= dru_pkg::NORM_LIMIT);
    case (cmd.sel)
      dru_pkg::SEL_LEFT:
        a = ($signed({{2{raw_box[0][AW-1]}}, raw_box[0]}) <<< 1) -
            $signed({{2{raw_box[2][AW-1]}}, raw_box[2]});
      dru_pkg::SEL_TOP:
        a = ($signed({{2{raw_box[1][AW-1]}}, raw_box[1]}) <<< 1) -
            $signed({{2{raw_box[3][AW-1]}}, raw_box[3]});
      dru_pkg::SEL_WIDTH:  a = $signed({{2{raw_box[2][AW-1]}}, raw_box[2]});
      default:             a = $signed({{2{raw_box[3][AW-1]}}, raw_box[3]});
    endcase
    mag = a[33] ? 33'(-a) : a[32:0];
    f   = (cmd.sel == dru_pkg::SEL_LEFT || cmd.sel == dru_pkg::SEL_WIDTH) ? fw_eff : fh_eff;
    if (norm) m = 13'd1;
    else m = (cmd.sel == dru_pkg::SEL_LEFT || cmd.sel == dru_pkg::SEL_WIDTH) ? mw_eff : mh_eff;
    pm  = DW'(mag) * DW'(f);
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      dividend <= pm;
      neg      <= a[33];
      if (cmd.sel == dru_pkg::SEL_LEFT || cmd.sel == dru_pkg::SEL_TOP)
        divisor <= {m, 17'b0};
      else
        divisor <= {1'b0, m, 16'b0};
    end
  end

  dru_div #(.DW(DW), .DVW(DVW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (q)
  );

  assign status.div_busy = div_busy;

  logic [FW_W-1:0] left, top, bw, bh;
  logic [FW_W-1:0] lim_pos, lim_size;
  logic [FW_W-1:0] pos_val, size_val;

  always_comb begin
    if (cmd.sel == dru_pkg::SEL_LEFT || cmd.sel == dru_pkg::SEL_WIDTH) begin
      lim_pos  = fw_eff - 1'b1;
      lim_size = fw_eff - left;
    end else begin
      lim_pos  = fh_eff - 1'b1;
      lim_size = fh_eff - top;
    end
    if (neg) pos_val = '0;
    else if (q > DW'(lim_pos)) pos_val = lim_pos;
    else pos_val = FW_W'(q);
    if (neg || q == '0) size_val = FW_W'(1);
    else if (q > DW'(lim_size)) size_val = lim_size;
    else size_val = FW_W'(q);
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      case (cmd.sel)
        dru_pkg::SEL_LEFT:  left <= pos_val;
        dru_pkg::SEL_TOP:   top  <= pos_val;
        dru_pkg::SEL_WIDTH: bw   <= size_val;
        default:            bh   <= size_val;
      endcase
    end
  end

  // box output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      box_left    <= dru_pkg::LEFT_W'(left);
      box_top     <= dru_pkg::LEFT_W'(top);
      box_width   <= dru_pkg::DIM_W'(bw);
      box_height  <= dru_pkg::DIM_W'(bh);
      class_index <= snap_cls;
      confidence  <= conf_sat;
    end
  end

endmodule

// File: hw/rtl/detection_row_decoder_core.sv
// ----------------------------------------------------------------------------
// detection_row_decoder_core
// Decodes streamed prediction rows into thresholded, scaled pixel boxes.
// ----------------------------------------------------------------------------
// attr: one Q16.16 attribute per transaction, clamped row_length per row.
// box:  at most one box per row (left, top, width, height, class, confidence).
// cfg:  register writes (index, data), always ready; write only while idle.
// Attributes are taken one per cycle inside a row. After the last attribute
// of a row attr.ready drops while the row is finished: the confidence
// product (ST_MUL) and threshold test (ST_DECIDE), then, for a kept box,
// four box divisions on one shared restoring divider, each of
// 33 + clog2(MAX_FRAME_DIM+1) quotient bits (46 at the default frame limit).
// A kept box is loaded into the box output register and held there until
// box.ready; attr.ready returns in the same cycle as the load. A stalled
// receiver holds attr.ready low only when the next kept box is finished
// while the previous one still waits. Rows without a box return to
// accepting after ST_DECIDE.
// Reset (rst, synchronous) restores the register defaults and starts a new
// row with no box pending.
// ----------------------------------------------------------------------------
module detection_row_decoder_core #(
  parameter int MAX_ROW_LENGTH = dru_pkg::MAX_ROW_LENGTH_DEF,
  parameter int MAX_FRAME_DIM  = dru_pkg::MAX_FRAME_DIM_DEF
) (
  input logic     clk,
  input logic     rst,
  dru_attr_if.sink  attr,
  dru_box_if.source box,
  dru_cfg_if.sink   cfg
);

  dru_pkg::cmd_t    cmd;
  dru_pkg::status_t status;

  assign cfg.ready = 1'b1;

  dru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (attr.valid),
    .in_ready  (attr.ready),
    .out_valid (box.valid),
    .out_ready (box.ready),
    .status    (status),
    .cmd       (cmd)
  );

  dru_dp #(
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
    .MAX_FRAME_DIM  (MAX_FRAME_DIM)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .attribute_value (attr.attribute_value),
    .cfg_valid       (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .box_left        (box.box_left),
    .box_top         (box.box_top),
    .box_width       (box.box_width),
    .box_height      (box.box_height),
    .class_index     (box.class_index),
    .confidence      (box.confidence)
  );

endmodule

// File: hw/rtl/dru_checker.sv
// ----------------------------------------------------------------------------
// dru_checker
// Port-level checks of the detection row decoder, bound to the top level.
// ----------------------------------------------------------------------------
module dru_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [dru_pkg::CONF_W-1:0]   confidence
);

  // a pending box is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("box dropped before transaction");

  // a pending box keeps its confidence
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(confidence))
    else $error("box changed while pending");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

  a_conf_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> confidence <= 17'd65536)
    else $error("confidence above one");

  a_box_after_row: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("box without finished row");

endmodule

bind detection_row_decoder_core dru_checker u_dru_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (attr.ready),
  .out_valid  (box.valid),
  .out_ready  (box.ready),
  .confidence (box.confidence)
);

// File: tb/tb_detection_row_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_detection_row_decoder_core
// Streams prediction rows into the decoder under several register settings,
// predicts each kept box from an in-bench model and checks every box output
// transaction, field by field, in order. Random idle bursts on both sides.
// ----------------------------------------------------------------------------
module tb_detection_row_decoder_core;

  localparam int SETTLE_CYCLES = 260;
  localparam int END_CYCLES    = 300;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int CALM_ITEMS    = 120;

  typedef enum logic [1:0] {ITEM_ATTR, ITEM_CFG, ITEM_SETTLE} item_kind_t;

  typedef struct {
    item_kind_t        kind;
    dru_pkg::reg_idx_t idx;
    logic [31:0]       data;
  } item_t;

  typedef struct packed {
    logic [dru_pkg::LEFT_W-1:0] box_left;
    logic [dru_pkg::LEFT_W-1:0] box_top;
    logic [dru_pkg::DIM_W-1:0]  box_width;
    logic [dru_pkg::DIM_W-1:0]  box_height;
    logic [dru_pkg::CLS_W-1:0]  class_index;
    logic [dru_pkg::CONF_W-1:0] confidence;
  } box_t;

  logic clk;
  logic rst;

  dru_attr_if attr_if();
  dru_box_if  box_if();
  dru_cfg_if  cfg_if();

  detection_row_decoder_core DUT (
    .clk  (clk),
    .rst  (rst),
    .attr (attr_if),
    .box  (box_if),
    .cfg  (cfg_if)
  );

  item_t pending[$];
  box_t  box_expect[$];

  // decoder state kept by the bench
  longint reg_frame_w, reg_frame_h, reg_model_w, reg_model_h;
  longint reg_row_len, reg_class_cnt, reg_thresh;
  longint attr_cnt, obj_val, best_val, best_cls;
  longint raw_box[4];
  bit     class_seen;

  int errors;
  int attrs_total;
  int attrs_sent;
  int boxes_seen;
  int rows_done;
  int cfg_writes;
  int quiet;
  int gap;
  int stall;
  int cycles;
  bit calm;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic decoder_reset();
    reg_frame_w = 640; reg_frame_h = 480;
    reg_model_w = 640; reg_model_h = 640;
    reg_row_len = 85; reg_class_cnt = 0; reg_thresh = 16384;
    foreach (raw_box[i]) raw_box[i] = 0;
    obj_val = 0;
    attr_cnt = 0; best_val = 0; best_cls = 0; class_seen = 0;
  endtask

  task automatic write_register(input dru_pkg::reg_idx_t idx,
                                input logic [dru_pkg::CFG_DAT_W-1:0] d);
    case (idx)
      dru_pkg::REG_FRAME_WIDTH:  reg_frame_w = d[12:0];
      dru_pkg::REG_FRAME_HEIGHT: reg_frame_h = d[12:0];
      dru_pkg::REG_MODEL_WIDTH:  reg_model_w = d[12:0];
      dru_pkg::REG_MODEL_HEIGHT: reg_model_h = d[12:0];
      dru_pkg::REG_ROW_LENGTH:   reg_row_len = d[10:0];
      dru_pkg::REG_CLASS_COUNT:  reg_class_cnt = d[9:0];
      dru_pkg::REG_THRESHOLD:    reg_thresh = d[16:0];
      default: ;
    endcase
  endtask

  function automatic longint clampl(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic bit decode_attribute(input logic signed [31:0] av, output box_t b);
    longint v, len, start, c, objn, p, conf, fw, fh, mw, mh;
    longint left, top, bw, bh, cx, cy, w, h;
    bit hit;
    b = '0;
    v = av;
    len = clampl(reg_row_len, dru_pkg::MIN_ROW_LENGTH, dru_pkg::MAX_ROW_LENGTH_DEF);
    if (reg_class_cnt != 0) start = (len == reg_class_cnt + 4) ? 4 : 5;
    else start = (len >= dru_pkg::IMPLICIT_MIN_LEN && len != dru_pkg::DEFAULT_ROW_MARK) ? 4 : 5;
    if (attr_cnt >= len) begin
      attr_cnt = 0; best_val = 0; best_cls = 0; class_seen = 0;
    end
    c = attr_cnt;
    if (c < 4) raw_box[c] = v;
    if (c == 4) obj_val = v;
    if (c >= start && v > best_val) begin
      best_val = v;
      best_cls = (c - start) & 1023;
      class_seen = 1;
    end
    if (c + 1 < len) begin
      attr_cnt = c + 1;
      return 0;
    end
    rows_done++;
    objn = (start == 4) ? 65536 : obj_val;
    p = objn * best_val;
    conf = (p >= 0) ? p / 65536 : -((-p + 65535) / 65536);
    hit = class_seen && conf >= reg_thresh;
    b.class_index = best_cls[dru_pkg::CLS_W-1:0];
    attr_cnt = 0; best_val = 0; best_cls = 0; class_seen = 0;
    if (!hit) return 0;
    cx = raw_box[0]; cy = raw_box[1]; w = raw_box[2]; h = raw_box[3];
    fw = clampl(reg_frame_w, 1, dru_pkg::MAX_FRAME_DIM_DEF);
    fh = clampl(reg_frame_h, 1, dru_pkg::MAX_FRAME_DIM_DEF);
    mw = reg_model_w != 0 ? reg_model_w : 1;
    mh = reg_model_h != 0 ? reg_model_h : 1;
    if (cx >= 0 && cy >= 0 && w > 0 && h > 0 && cx <= 98304 && cy <= 98304 &&
        w <= 98304 && h <= 98304) begin
      mw = 1;
      mh = 1;
    end
    left = ((2 * cx - w) * fw) / (2 * 65536 * mw);
    top  = ((2 * cy - h) * fh) / (2 * 65536 * mh);
    bw   = (w * fw) / (65536 * mw);
    bh   = (h * fh) / (65536 * mh);
    left = clampl(left, 0, fw - 1);
    top  = clampl(top, 0, fh - 1);
    bw   = clampl(bw, 1, fw - left);
    bh   = clampl(bh, 1, fh - top);
    b.box_left   = left[dru_pkg::LEFT_W-1:0];
    b.box_top    = top[dru_pkg::LEFT_W-1:0];
    b.box_width  = bw[dru_pkg::DIM_W-1:0];
    b.box_height = bh[dru_pkg::DIM_W-1:0];
    b.confidence = dru_pkg::CONF_W'(clampl(conf, 0, 65536));
    return 1;
  endfunction

  task automatic push_attr(input logic [31:0] v);
    item_t it;
    it.kind = ITEM_ATTR; it.idx = dru_pkg::REG_FRAME_WIDTH; it.data = v;
    pending.insert(pending.size(), it);
    attrs_total++;
  endtask

  task automatic push_cfg(input dru_pkg::reg_idx_t idx, input logic [31:0] v);
    item_t it;
    it.kind = ITEM_SETTLE; it.idx = idx; it.data = v;
    pending.insert(pending.size(), it);
    it.kind = ITEM_CFG;
    pending.insert(pending.size(), it);
  endtask

  function automatic logic [31:0] pick_dim();
    case ($urandom_range(7))
      0: return 1;
      1: return 4096;
      2: return $urandom_range(0, 8191);
      default: return $urandom_range(16, 1920);
    endcase
  endfunction

  // one row of random content: normalized, pixel or noise
  task automatic push_row(input int len);
    int mode;
    mode = $urandom_range(9);
    for (int i = 0; i < len; i++) begin
      if (mode == 0 || $urandom_range(40) == 0) push_attr($urandom);
      else if (i < 4) begin
        if (mode < 6) push_attr($urandom_range(0, 98304) + (i >= 2 ? 1 : 0));
        else if ($urandom_range(5) == 0) push_attr(-($urandom_range(0, 300) << 16));
        else push_attr($urandom_range(0, 1000) << 16 | $urandom_range(0, 65535));
      end else if ($urandom_range(9) == 0) push_attr(-$urandom_range(1, 65536));
      else push_attr($urandom_range(0, 65536));
    end
  endtask

  // driver
  always @(posedge clk) begin
    logic nav, ncv;
    box_t exp_box;
    if (rst) begin
      attr_if.valid <= 1'b0;
      cfg_if.valid <= 1'b0;
      quiet = SETTLE_CYCLES;
    end else begin
      nav = attr_if.valid;
      ncv = cfg_if.valid;
      if (attr_if.valid && attr_if.ready) begin
        if (decode_attribute(attr_if.attribute_value, exp_box))
          box_expect.insert(box_expect.size(), exp_box);
        nav = 1'b0;
        quiet = 0;
        attrs_sent++;
        if (attrs_sent > attrs_total - CALM_ITEMS) calm = 1;
        if (!calm && $urandom_range(3) == 0) gap = $urandom_range(1, 3);
      end else if (quiet < SETTLE_CYCLES) begin
        quiet++;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        write_register(dru_pkg::reg_idx_t'(cfg_if.index), cfg_if.data);
        cfg_writes++;
        ncv = 1'b0;
      end
      if (!nav && !ncv && pending.size() > 0) begin
        if (gap > 0) begin
          gap--;
        end else begin
          case (pending[0].kind)
            ITEM_ATTR: begin
              nav = 1'b1;
              attr_if.attribute_value <= pending[0].data;
              void'(pending.pop_front());
            end
            ITEM_CFG: begin
              ncv = 1'b1;
              cfg_if.index <= pending[0].idx;
              cfg_if.data <= pending[0].data[dru_pkg::CFG_DAT_W-1:0];
              void'(pending.pop_front());
            end
            default: begin
              if (box_expect.size() == 0 && quiet >= SETTLE_CYCLES) void'(pending.pop_front());
            end
          endcase
        end
      end
      attr_if.valid <= nav;
      cfg_if.valid <= ncv;
    end
  end

  // monitor
  always @(posedge clk) begin
    box_t e;
    if (rst) begin
      box_if.ready <= 1'b0;
    end else begin
      if (box_if.valid && box_if.ready) begin
        boxes_seen++;
        if (box_expect.size() == 0) begin
          errors++;
          $display("%0t: unexpected box, actual %0d %0d %0d %0d cls %0d conf %0d", $time,
                   box_if.box_left, box_if.box_top, box_if.box_width, box_if.box_height,
                   box_if.class_index, box_if.confidence);
        end else begin
          e = box_expect.pop_front();
          if (box_if.box_left !== e.box_left) begin
            errors++;
            $display("%0t: box_left expected %0d actual %0d", $time, e.box_left,
                     box_if.box_left);
          end
          if (box_if.box_top !== e.box_top) begin
            errors++;
            $display("%0t: box_top expected %0d actual %0d", $time, e.box_top, box_if.box_top);
          end
          if (box_if.box_width !== e.box_width) begin
            errors++;
            $display("%0t: box_width expected %0d actual %0d", $time, e.box_width,
                     box_if.box_width);
          end
          if (box_if.box_height !== e.box_height) begin
            errors++;
            $display("%0t: box_height expected %0d actual %0d", $time, e.box_height,
                     box_if.box_height);
          end
          if (box_if.class_index !== e.class_index) begin
            errors++;
            $display("%0t: class_index expected %0d actual %0d", $time, e.class_index,
                     box_if.class_index);
          end
          if (box_if.confidence !== e.confidence) begin
            errors++;
            $display("%0t: confidence expected %0d actual %0d", $time, e.confidence,
                     box_if.confidence);
          end
        end
      end
      if (stall > 0) begin
        stall--;
        box_if.ready <= 1'b0;
      end else begin
        box_if.ready <= 1'b1;
        if (!calm && $urandom_range(7) == 0) stall = $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_detection_row_decoder_core NOT OK");
      $finish;
    end
  end

  initial begin
    int len, cls;
    attr_if.valid = 1'b0;
    attr_if.attribute_value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = dru_pkg::REG_FRAME_WIDTH;
    cfg_if.data = '0;
    box_if.ready = 1'b0;
    errors = 0; attrs_total = 0; attrs_sent = 0; boxes_seen = 0; rows_done = 0;
    cfg_writes = 0; gap = 0; stall = 0; cycles = 0; calm = 0;
    decoder_reset();
    rst = 1'b1;

    // short rows, explicit objectness
    push_cfg(dru_pkg::REG_ROW_LENGTH, 6);
    push_attr(32'h8000); push_attr(32'h8000); push_attr(32'h4000); push_attr(32'h4000);
    push_attr(32'h10000); push_attr(32'h10000);
    // extremes, saturated confidence, unnormalized box
    push_attr(32'h7fffffff); push_attr(32'h80000000); push_attr(32'h7fffffff);
    push_attr(32'h80000000); push_attr(32'h7fffffff); push_attr(32'h7fffffff);
    // no class above zero
    push_attr(32'h0); push_attr(32'h0); push_attr(32'h0); push_attr(32'h0);
    push_attr(32'h10000); push_attr(32'hffff0000);
    // implicit objectness, tied scores keep the first
    push_cfg(dru_pkg::REG_CLASS_COUNT, 2);
    push_cfg(dru_pkg::REG_THRESHOLD, 0);
    push_attr(32'h18000); push_attr(32'h0); push_attr(32'h18000); push_attr(32'h10000);
    push_attr(32'h8000); push_attr(32'h8000);
    push_cfg(dru_pkg::REG_THRESHOLD, 65536);
    push_attr(32'h8000); push_attr(32'h8000); push_attr(32'h1); push_attr(32'h1);
    push_attr(32'h10000); push_attr(32'h20000);

    for (int ph = 0; attrs_total < 760; ph++) begin
      push_cfg(dru_pkg::REG_FRAME_WIDTH, pick_dim());
      push_cfg(dru_pkg::REG_FRAME_HEIGHT, pick_dim());
      push_cfg(dru_pkg::REG_MODEL_WIDTH, pick_dim());
      push_cfg(dru_pkg::REG_MODEL_HEIGHT, pick_dim());
      if (ph == 1) begin
        len = 85; cls = 0;
      end else begin
        len = ($urandom_range(7) == 0) ? $urandom_range(0, 5) : $urandom_range(6, 16);
        case ($urandom_range(3))
          0: cls = 0;
          1: cls = (len > 4) ? len - 4 : 0;
          default: cls = $urandom_range(0, 1023);
        endcase
      end
      push_cfg(dru_pkg::REG_ROW_LENGTH, len);
      push_cfg(dru_pkg::REG_CLASS_COUNT, cls);
      case ($urandom_range(5))
        0: push_cfg(dru_pkg::REG_THRESHOLD, 0);
        1: push_cfg(dru_pkg::REG_THRESHOLD, 65536);
        2: push_cfg(dru_pkg::REG_THRESHOLD, 131071);
        default: push_cfg(dru_pkg::REG_THRESHOLD, $urandom_range(0, 20000));
      endcase
      if (len < dru_pkg::MIN_ROW_LENGTH) len = dru_pkg::MIN_ROW_LENGTH;
      for (int r = $urandom_range(2, 8); r > 0; r--) push_row(len);
      // leave a partial row for the next setting
      if ($urandom_range(2) == 0)
        for (int i = $urandom_range(1, len - 1); i > 0; i--) push_attr($urandom);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (pending.size() == 0 && !attr_if.valid && !cfg_if.valid);
    wait (box_expect.size() == 0);
    repeat (END_CYCLES) @(posedge clk);
    $display("%0d attributes in %0d rows over %0d register writes", attrs_sent, rows_done,
             cfg_writes);
    $display("%0d boxes compared, %0d mismatches", boxes_seen, errors);
    if (errors == 0 && box_expect.size() == 0) begin
      $display("tb_detection_row_decoder_core OK");
    end else begin
      $display("tb_detection_row_decoder_core NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/dru_pkg.sv
hw/rtl/dru_if.sv
hw/rtl/dru_ctrl.sv
hw/rtl/dru_div.sv
hw/rtl/dru_dp.sv
hw/rtl/detection_row_decoder_core.sv
hw/rtl/dru_checker.sv
tb/tb_detection_row_decoder_core.sv
